// ----- design/dmc_pkg.sv -----
`default_nettype none

package dmc_pkg;

	// line count register and derived result widths
	localparam int NUM_LINES_W = 11;
	localparam logic [NUM_LINES_W-1:0] NUM_LINES_RESET = 11'd1024;
	localparam int LINE_IDX_W = 10;
	localparam int CNT_W = 32;

	// address bits folded into the remainder per cycle
	localparam int DIGIT_W = 4;

	typedef logic [NUM_LINES_W-1:0] num_lines_t;
	typedef logic [CNT_W-1:0] count_t;

endpackage

`default_nettype wire

// ----- design/direct_mapped_cache_hit_counter_core.sv -----
`default_nettype none

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-------------------------------------------
// in       | request   | in_valid / in_ready   | address
// out      | result    | out_valid / out_ready | hit, line_no, hits_total, misses_total
// cfg      | write     | cfg_valid / cfg_ready | cfg_data (num_lines)
//
// requests are taken one at a time: the remainder unit folds four address bits a
// cycle, then come the done handover, one line store read and one compare/write,
// and only then is the next request taken
// after reset a clearing pass zeroes every line of the line store with in_ready low
// a waiting result sits in the output register; the next request is taken meanwhile
// and its compare stage holds until the output register frees up

module direct_mapped_cache_hit_counter_core #(
	parameter int LINES = 1024,
	parameter int ADDR_BITS = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ADDR_BITS-1:0]  address,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       hit,
	output logic [dmc_pkg::LINE_IDX_W-1:0] line_no,
	output dmc_pkg::count_t            hits_total,
	output dmc_pkg::count_t            misses_total,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire dmc_pkg::num_lines_t   cfg_data
);

	import dmc_pkg::*;

	localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(LINES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_CMP
	} state_t;

	state_t state_q;

	// configuration
	num_lines_t num_lines_q;
	num_lines_t lines_eff;

	// request and line store access
	logic [ADDR_BITS-1:0] addr_q;
	logic [IDX_W-1:0]     clr_q;
	logic                 div_done;
	num_lines_t           rem;
	logic [IDX_W-1:0]     line;
	logic [ADDR_BITS-1:0] rd_data;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [ADDR_BITS-1:0] ram_wdata;
	logic                 match;
	logic                 retire;

	// counters and output register
	count_t hits_q;
	count_t misses_q;
	logic   out_valid_q;
	logic   hit_q;
	logic [LINE_IDX_W-1:0] line_no_q;
	count_t hits_total_q;
	count_t misses_total_q;

	// config is always taken; the user must write only while no request is in flight, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_lines_q <= NUM_LINES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_lines_q <= cfg_data;
		end
	end

	// zero lines act as one, more than the store holds saturates
	always_comb begin
		if (num_lines_q == '0) begin
			lines_eff = NUM_LINES_W'(1);
		end else if (32'(num_lines_q) > 32'(LINES)) begin
			lines_eff = NUM_LINES_W'(LINES);
		end else begin
			lines_eff = num_lines_q;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// address modulo line count, multi-cycle
	dmc_mod #(
		.ADDR_BITS(ADDR_BITS)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_valid && in_ready),
		.dividend(address),
		.divisor (lines_eff),
		.done    (div_done),
		.rem     (rem)
	);

	// remainder is below the line count, so it always fits the store
	assign line = IDX_W'(rem);

	assign match  = (rd_data == addr_q);
	assign retire = (state_q == ST_CMP) && (!out_valid_q || out_ready);

	// clearing pass writes zero, a miss writes the new address back
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = retire && !match;
			ram_waddr = line;
			ram_wdata = addr_q;
		end
	end

	dmc_ram #(
		.WIDTH(ADDR_BITS),
		.DEPTH(LINES),
		.AW   (IDX_W)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (state_q == ST_READ),
		.raddr(line),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_LINE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (retire) begin
						if (match) begin
							hits_q <= hits_q + 1'b1;
						end else begin
							misses_q <= misses_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request address and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			addr_q <= address;
		end
		if (retire) begin
			hit_q          <= match;
			line_no_q      <= rem[LINE_IDX_W-1:0];
			hits_total_q   <= match ? hits_q + 1'b1 : hits_q;
			misses_total_q <= match ? misses_q : misses_q + 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign line_no      = line_no_q;
	assign hits_total   = hits_total_q;
	assign misses_total = misses_total_q;

endmodule

`default_nettype wire

// ----- design/dmc_ram.sv -----
`default_nettype none

module dmc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/dmc_mod.sv -----
`default_nettype none

module dmc_mod #(
	parameter int ADDR_BITS = 48
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [ADDR_BITS-1:0]   dividend,
	input  wire dmc_pkg::num_lines_t    divisor,
	output logic                        done,
	output dmc_pkg::num_lines_t         rem
);

	import dmc_pkg::*;

	localparam int STEPS = (ADDR_BITS + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W = STEPS * DIGIT_W;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic [PAD_W-1:0]  shift_q;
	num_lines_t        rem_q;
	num_lines_t        divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	num_lines_t        rem_next;

	// restoring remainder, one digit of the dividend per cycle, msb first
	always_comb begin
		logic [NUM_LINES_W:0] t;
		num_lines_t r;
		r = rem_q;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {r, shift_q[PAD_W-1-i]};
			if (t >= {1'b0, divisor_q}) begin
				r = NUM_LINES_W'(t - {1'b0, divisor_q});
			end else begin
				r = t[NUM_LINES_W-1:0];
			end
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q   <= PAD_W'(dividend);
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[PAD_W-DIGIT_W-1:0], DIGIT_W'(0)};
			rem_q   <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dmc_pkg::*;

	localparam int LINES = 1024;
	localparam int ADDR_BITS = 48;
	// requests per random phase and number of phases
	localparam int PHASE_ITEMS = 115;
	localparam int NUM_PHASES = 10;
	// receiver hold-off that backs the block up into its input
	localparam int LONG_HOLD = 300;
	// cycles to watch for stray results once everything has drained
	localparam int TAIL_CYCLES = 40;

	typedef logic [ADDR_BITS-1:0] addr_t;

	// one lookup result as the block reports it
	typedef struct packed {
		logic hit;
		logic [LINE_IDX_W-1:0] line_idx;
		count_t hits;
		count_t misses;
	} lookup_result_t;

	// cache model plus queue of lookups still owed by the block
	class lookup_scoreboard;
		addr_t line_addr [LINES];
		count_t hit_total;
		count_t miss_total;
		num_lines_t lines_reg;
		lookup_result_t owed_q [$];
		int fail_count;

		function new();
			foreach (line_addr[i]) line_addr[i] = '0;
			hit_total = '0;
			miss_total = '0;
			lines_reg = NUM_LINES_RESET;
			fail_count = 0;
		endfunction

		function void set_lines(num_lines_t n);
			lines_reg = n;
		endfunction

		// zero means one line, anything past the store size clamps to it
		function int unsigned lines_in_use();
			int unsigned n;
			n = lines_reg;
			if (n == 0) n = 1;
			if (n > LINES) n = LINES;
			return n;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void note_request(addr_t a);
			lookup_result_t r;
			longint unsigned line;
			line = 64'(a) % 64'(lines_in_use());
			r.hit = (line_addr[line] == a);
			if (r.hit) begin
				hit_total++;
			end else begin
				miss_total++;
				line_addr[line] = a;
			end
			r.line_idx = line[LINE_IDX_W-1:0];
			r.hits = hit_total;
			r.misses = miss_total;
			owed_q.insert(owed_q.size(), r);
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $time, what);
			fail_count++;
		endtask

		task check_result(logic got_hit, logic [LINE_IDX_W-1:0] got_idx,
			count_t got_hits, count_t got_misses);
			lookup_result_t want;
			if (owed_q.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			want = owed_q.pop_front();
			if (got_hit !== want.hit)
				report_mismatch($sformatf("hit %b, want %b", got_hit, want.hit));
			if (got_idx !== want.line_idx)
				report_mismatch($sformatf("line_no %0d, want %0d", got_idx, want.line_idx));
			if (got_hits !== want.hits)
				report_mismatch($sformatf("hits_total %0d, want %0d", got_hits, want.hits));
			if (got_misses !== want.misses)
				report_mismatch($sformatf("misses_total %0d, want %0d", got_misses,
					want.misses));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	addr_t address;
	logic out_valid;
	logic out_ready;
	logic hit;
	logic [LINE_IDX_W-1:0] line_no;
	count_t hits_total;
	count_t misses_total;
	logic cfg_valid;
	logic cfg_ready;
	num_lines_t cfg_data;

	lookup_scoreboard sb;
	// random bursts of idling on both sides while set
	bit idle_on;
	// raised by the stimulus, consumed by the result sink
	bit long_hold_req;
	// recently sent addresses, replayed to produce hits
	addr_t recent [$];

	direct_mapped_cache_hit_counter_core #(
		.LINES(LINES),
		.ADDR_BITS(ADDR_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.address(address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.line_no(line_no),
		.hits_total(hits_total),
		.misses_total(misses_total),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// offer one request, optionally after an idle burst, and hold it until taken
	task automatic send_request(input addr_t a);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		address <= a;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		sb.note_request(a);
		recent.insert(recent.size(), a);
		if (recent.size() > 32) void'(recent.pop_front());
	endtask

	// stop offering and wait until every owed result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// line count only changes while the block is empty
	task automatic write_num_lines(input num_lines_t n);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		sb.set_lines(n);
		cfg_valid <= 1'b0;
	endtask

	// mix of replays, conflicting lines, corner values and fully random addresses
	function automatic addr_t pick_address(int unsigned lines_now);
		addr_t a;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		if (kind < 30 && recent.size() > 0)
			a = recent[$urandom_range(0, recent.size() - 1)];
		else if (kind < 55)
			a = addr_t'($urandom_range(0, 7)) * lines_now + addr_t'($urandom_range(0, 3));
		else if (kind < 62) begin
			case ($urandom_range(0, 2))
				0: a = '0;
				1: a = '1;
				default: a = '1 - addr_t'($urandom_range(0, 4096));
			endcase
		end else
			a = addr_t'({$urandom, $urandom});
		return a;
	endfunction

	// result sink: checks every taken result and drives out_ready stalls
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				sb.check_result(hit, line_no, hits_total, misses_total);
			if (long_hold_req) begin
				// long back-pressure, the sender keeps pushing meanwhile
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 5);
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		num_lines_t phase_lines [NUM_PHASES];
		int p;
		int i;
		sb = new();
		idle_on = 1'b1;
		long_hold_req = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		address <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset line count of 1024
		// address zero hits a never written line
		send_request('0);
		send_request('1);
		send_request('1);
		// conflict on line zero, then zero itself misses
		send_request(addr_t'(1024));
		send_request('0);
		send_request('0);
		send_request(addr_t'(1023));
		send_request(addr_t'(48'h8000_0000_0000));

		// zero line count behaves as a single line
		write_num_lines('0);
		send_request('0);
		send_request(addr_t'(5));
		send_request(addr_t'(5));
		send_request(addr_t'(1023));

		// all-ones count clamps to the store size, old contents kept
		write_num_lines('1);
		send_request(addr_t'(1023));
		send_request(addr_t'(2047));
		send_request(addr_t'(5));

		// smallest legal count
		write_num_lines(num_lines_t'(1));
		send_request(addr_t'(7));
		send_request(addr_t'(7));

		// just above the store size
		write_num_lines(num_lines_t'(1025));
		send_request(addr_t'(1027));
		send_request(addr_t'(1027));

		// largest legal count, alternating bit patterns
		write_num_lines(num_lines_t'(1024));
		send_request(addr_t'(2047));
		send_request(addr_t'(48'h7FFF_FFFF_FFFF));
		send_request(addr_t'(48'h5555_5555_5555));
		send_request(addr_t'(48'hAAAA_AAAA_AAAA));

		// random phases, each with its own line count
		phase_lines = '{num_lines_t'(3), num_lines_t'(7), num_lines_t'(1024), num_lines_t'(0),
			num_lines_t'(2047), num_lines_t'(100), num_lines_t'(1),
			num_lines_t'($urandom_range(1, 2047)), num_lines_t'(1000), num_lines_t'(1024)};
		for (p = 0; p < NUM_PHASES; p++) begin
			write_num_lines(phase_lines[p]);
			// quiet stretches, and none at all in phase 3 and the closing phase
			idle_on = (p != 3) && (p != NUM_PHASES - 1);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 30) long_hold_req = 1'b1;
				// sender pause until the block has emptied
				if (p == 5 && i == 60) drain_results();
				send_request(pick_address(sb.lines_in_use()));
			end
		end

		drain_results();
		// watch for anything extra coming out
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
